>>> rtl/rjpd_pkg.sv
// ----------------------------------------------------------------------------
// rjpd_pkg
// Shared types and constants of the random jitter packet delay block.
// ----------------------------------------------------------------------------
package rjpd_pkg;

    localparam int DELAY_W = 13;
    localparam int TIME_W  = 32;
    localparam int TAG_W   = 16;
    localparam int RND_W   = 15;
    localparam int CAUSE_W = 2;
    localparam int CNT_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CAUSE_W-1:0] CAUSE_PASS  = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_DUE   = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_FLUSH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT = 2'd3;

    // Input tuser: op. Input tdata: now_ms, packet_tag, is_outbound, random_value.
    localparam int IN_BITS = TIME_W + TAG_W + 1 + RND_W;
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
    // Output tuser: cause. Output tdata: out_tag, held_count (last travels as tlast).
    localparam int OUT_BITS = TAG_W + CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture input item
        logic mod_start;  // start modulo unit
        logic append;     // write new entry at tail
        logic emit;       // load output register
        logic emit_pass;  // output is the arriving packet
        logic [CAUSE_W-1:0] cause;
        logic emit_last;
        logic rd_req;     // read entry at scan index
        logic scan_clr;   // scan index to zero
        logic scan_inc;   // advance scan index
        logic shift_start;// remove entry at scan index
        logic shift_step; // move one entry down
        logic flush_load; // load flush counter
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic hold_ok;    // direction enabled and room
        logic scan_end;   // scan index at count
        logic entry_due;  // entry just read is due
        logic shift_done;
        logic full;
        logic flush_end;
        logic any_emitted;
        logic out_busy;   // output register still occupied
    } t_sts;

endpackage

>>> rtl/rjpd_ctrl.sv
// ----------------------------------------------------------------------------
// rjpd_ctrl
// Sequencer: arrival, due scan with removal, overflow flush.
// ----------------------------------------------------------------------------
module rjpd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_op,
    output logic            o_idle,
    output rjpd_pkg::t_cmd  o_cmd,
    input  rjpd_pkg::t_sts  i_sts
);
    import rjpd_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_MOD    = 12'b000000000010,
        S_ARR    = 12'b000000000100,
        S_SREAD  = 12'b000000001000,
        S_SWAIT  = 12'b000000010000,
        S_SCHK   = 12'b000000100000,
        S_SSHIFT = 12'b000001000000,
        S_FCHK   = 12'b000010000000,
        S_FREAD  = 12'b000100000000,
        S_FWAIT  = 12'b001000000000,
        S_FSHIFT = 12'b010000000000,
        S_FIN    = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_idle = (r_state == S_IDLE);

    // Every emit happens only when the output register is free; the held-back
    // result is sent with the last flag in S_FIN, again once the register is free.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = i_op ? S_MOD : S_SREAD;
                end
            end
            S_MOD: begin
                o_cmd.mod_start = 1'b1;
                n_state = S_ARR;
            end
            S_ARR: begin
                if (i_sts.mod_done) begin
                    if (i_sts.hold_ok) begin
                        o_cmd.append = 1'b1;
                        o_cmd.scan_clr = 1'b1;
                        n_state = S_SREAD;
                    end else if (!i_sts.out_busy) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.emit_pass = 1'b1;
                        o_cmd.cause = CAUSE_PASS;
                        o_cmd.scan_clr = 1'b1;
                        n_state = S_SREAD;
                    end
                end
            end
            S_SREAD: begin
                if (i_sts.scan_end) begin
                    o_cmd.flush_load = 1'b1;
                    n_state = S_FCHK;
                end else begin
                    o_cmd.rd_req = 1'b1;
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: n_state = S_SCHK;
            S_SCHK: begin
                if (!i_sts.entry_due) begin
                    o_cmd.scan_inc = 1'b1;
                    n_state = S_SREAD;
                end else if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.cause = CAUSE_DUE;
                    o_cmd.shift_start = 1'b1;
                    n_state = S_SSHIFT;
                end
            end
            S_SSHIFT: begin
                if (i_sts.shift_done) n_state = S_SREAD;
                else                  o_cmd.shift_step = 1'b1;
            end
            S_FCHK: begin
                if (i_sts.full) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_FREAD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FREAD: begin
                if (i_sts.flush_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_req = 1'b1;
                    n_state = S_FWAIT;
                end
            end
            S_FWAIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.cause = CAUSE_FLUSH;
                    o_cmd.shift_start = 1'b1;
                    n_state = S_FSHIFT;
                end
            end
            S_FSHIFT: begin
                if (i_sts.shift_done) n_state = S_FREAD;
                else                  o_cmd.shift_step = 1'b1;
            end
            S_FIN: begin
                if (!i_sts.any_emitted || !i_sts.out_busy) begin
                    o_cmd.emit_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy)
        else $error("emit while output register occupied");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state != S_IDLE))
        else $error("accepted item did not start a sequence");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_sts.out_busy) |=> (r_state == S_IDLE))
        else $error("sequence end did not return to idle");

endmodule

>>> rtl/rjpd_dp.sv
// ----------------------------------------------------------------------------
// rjpd_dp
// Entry store, modulo unit, scan and shift logic, and output register.
// ----------------------------------------------------------------------------
module rjpd_dp #(
    parameter int CAPACITY    = 32,
    parameter int FLUSH_COUNT = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [rjpd_pkg::IN_W-1:0]         i_item,
    input  logic [rjpd_pkg::DELAY_W-1:0]      i_min,
    input  logic [rjpd_pkg::DELAY_W-1:0]      i_max,
    input  logic                              i_in_en,
    input  logic                              i_out_en,
    input  rjpd_pkg::t_cmd                    i_cmd,
    output rjpd_pkg::t_sts                    o_sts,
    input  logic                              i_out_take,
    output logic                              o_out_valid,
    output logic [rjpd_pkg::OUT_W-1:0]        o_out_data,
    output logic [rjpd_pkg::CAUSE_W-1:0]      o_out_user,
    output logic                              o_out_last
);
    import rjpd_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int MW = DELAY_W + 1;

    logic [TAG_W-1:0]  mem_tag [CAPACITY];
    logic [TIME_W-1:0] mem_due [CAPACITY];

    logic              r_dir;
    logic [TIME_W-1:0] r_now;
    logic [TAG_W-1:0]  r_tag;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_sh;
    logic [CNT_W-1:0]  r_flush;
    logic              r_emitted;
    logic [TAG_W-1:0]  r_rd_tag;
    logic [TIME_W-1:0] r_rd_due;
    // Modulo unit: restoring remainder, one dividend bit per cycle.
    logic [RND_W-1:0]  r_div;
    logic [MW-1:0]     r_rem;
    logic [MW-1:0]     r_den;
    logic [DELAY_W-1:0] r_lo;
    logic [4:0]        r_mcnt;
    logic              r_mbusy;
    // Shift: the move carries one entry per cycle.
    logic              r_sbusy;
    logic [TAG_W-1:0]  r_mv_tag;
    logic [TIME_W-1:0] r_mv_due;
    logic              r_mv_v;
    logic [CNT_W-1:0]  r_mv_a;

    logic              r_ov;
    logic [TAG_W-1:0]  r_otag;
    logic [CAUSE_W-1:0] r_ocause;
    logic [CNT_W-1:0]  r_ocnt;
    logic              r_olast;

    logic [DELAY_W-1:0] lo_w, hi_w;
    logic [MW-1:0]     rem_sh, rem_sub;
    logic [CNT_W-1:0]  cnt_after;

    always_comb begin
        lo_w = (i_min > i_max) ? i_max : i_min;
        hi_w = (i_min > i_max) ? i_min : i_max;
        rem_sh  = {r_rem[MW-2:0], r_div[RND_W-1]};
        rem_sub = rem_sh - r_den;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= i_item[0 +: TIME_W];
            r_tag <= i_item[TIME_W +: TAG_W];
            r_dir <= i_item[TIME_W + TAG_W];
            r_div <= i_item[1 + TIME_W + TAG_W +: RND_W];
            r_lo  <= lo_w;
            r_den <= {1'b0, hi_w - lo_w} + MW'(1);
            r_rem <= '0;
        end else if (r_mbusy) begin
            r_div <= {r_div[RND_W-2:0], 1'b0};
            r_rem <= (rem_sh >= r_den) ? rem_sub : rem_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mcnt  <= '0;
        end else if (i_cmd.mod_start) begin
            r_mbusy <= 1'b1;
            r_mcnt  <= 5'(RND_W);
        end else if (r_mbusy) begin
            r_mcnt  <= r_mcnt - 5'd1;
            if (r_mcnt == 5'd1) r_mbusy <= 1'b0;
        end
    end

    assign o_sts.mod_done = !r_mbusy && (r_mcnt == '0);
    assign o_sts.hold_ok  = (r_dir ? i_out_en : i_in_en) && (r_cnt < CNT_W'(CAPACITY));

    // Memory write and read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            mem_tag[r_cnt[AW-1:0]] <= r_tag;
            mem_due[r_cnt[AW-1:0]] <= r_now + TIME_W'(r_lo) + TIME_W'(r_rem);
        end else if (r_mv_v) begin
            mem_tag[r_mv_a[AW-1:0]] <= r_mv_tag;
            mem_due[r_mv_a[AW-1:0]] <= r_mv_due;
        end
        if (i_cmd.rd_req) begin
            r_rd_tag <= mem_tag[r_idx[AW-1:0]];
            r_rd_due <= mem_due[r_idx[AW-1:0]];
        end else if (r_sbusy) begin
            r_mv_tag <= mem_tag[r_sh[AW-1:0]];
            r_mv_due <= mem_due[r_sh[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mv_a <= r_sh - CNT_W'(1);
    end

    assign cnt_after = r_cnt - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_idx     <= '0;
            r_sh      <= '0;
            r_sbusy   <= 1'b0;
            r_mv_v    <= 1'b0;
            r_flush   <= '0;
            r_emitted <= 1'b0;
        end else begin
            r_mv_v <= r_sbusy;
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_emitted <= 1'b0;
            end
            if (i_cmd.emit) r_emitted <= 1'b1;
            if (i_cmd.append) r_cnt <= r_cnt + CNT_W'(1);
            if (i_cmd.scan_clr) r_idx <= '0;
            if (i_cmd.scan_inc) r_idx <= r_idx + CNT_W'(1);
            if (i_cmd.flush_load) r_flush <= CNT_W'(FLUSH_COUNT);
            if (i_cmd.shift_start) begin
                r_cnt   <= cnt_after;
                r_sh    <= r_idx + CNT_W'(1);
                r_sbusy <= (r_idx + CNT_W'(1)) < r_cnt;
                if (i_cmd.cause == CAUSE_FLUSH) r_flush <= r_flush - CNT_W'(1);
            end else if (r_sbusy) begin
                r_sh    <= r_sh + CNT_W'(1);
                r_sbusy <= (r_sh + CNT_W'(1)) <= r_cnt;
            end
        end
    end

    assign o_sts.shift_done = !r_sbusy && !r_mv_v;
    assign o_sts.scan_end   = (r_idx >= r_cnt);
    assign o_sts.entry_due  = (r_now >= r_rd_due);
    assign o_sts.full       = (r_cnt >= CNT_W'(CAPACITY));
    assign o_sts.flush_end  = (r_flush == '0) || (r_cnt == '0);
    assign o_sts.any_emitted = r_emitted;
    assign o_sts.out_busy   = r_ov && !i_out_take;

    // Output register. A result is held back one step so that the last
    // flag can be set on it when the sequence ends.
    logic [TAG_W-1:0] hold_tag;
    logic [CAUSE_W-1:0] hold_cause;
    logic [CNT_W-1:0] hold_cnt;
    always_comb begin
        hold_tag = r_rd_tag;
        hold_cause = i_cmd.cause;
        hold_cnt = cnt_after;
        if (i_cmd.emit && i_cmd.emit_pass) begin
            hold_tag = r_tag;
            hold_cnt = r_cnt;
        end
    end

    logic               r_pv;
    logic [TAG_W-1:0]   r_ptag;
    logic [CAUSE_W-1:0] r_pcause;
    logic [CNT_W-1:0]   r_pcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (r_ov && i_out_take) r_ov <= 1'b0;
            if (i_cmd.emit) begin
                r_pv <= 1'b1;
                if (r_pv) begin
                    r_ov <= 1'b1;
                    r_olast <= 1'b0;
                    r_otag <= r_ptag;
                    r_ocause <= r_pcause;
                    r_ocnt <= r_pcnt;
                end
                r_ptag <= hold_tag;
                r_pcause <= hold_cause;
                r_pcnt <= hold_cnt;
            end else if (i_cmd.emit_last && r_pv) begin
                r_pv <= 1'b0;
                r_ov <= 1'b1;
                r_olast <= 1'b1;
                r_otag <= r_ptag;
                r_ocause <= r_pcause;
                r_ocnt <= r_pcnt;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_last  = r_olast;
    assign o_out_user  = r_ocause;
    assign o_out_data  = OUT_W'({r_ocnt, r_otag});

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("held count beyond capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_take) |=> r_ov)
        else $error("result dropped before transaction");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_take) |=> ($stable(r_otag) && $stable(r_ocause) &&
                                   $stable(r_ocnt) && $stable(r_olast)))
        else $error("result changed before transaction");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> r_cnt < CNT_W'(CAPACITY))
        else $error("append into full store");

endmodule

>>> rtl/random_jitter_packet_delay.sv
// ----------------------------------------------------------------------------
// random_jitter_packet_delay
// Holds arriving packets for a random delay and releases them when due.
// ----------------------------------------------------------------------------
// One item is processed at a time. An item runs the serial modulo when it
// carries a packet, then checks each held entry, flushes entries when the store
// is full, and for every entry released or flushed moves each entry behind it
// down one place (the store has one write port). Each result waits for the
// consumer; the last result of an item is sent once the sequence ends and the
// output register is free.
module random_jitter_packet_delay #(
    parameter int CAPACITY    = 32,
    parameter int FLUSH_COUNT = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rjpd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rjpd_pkg::DELAY_W-1:0]  i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // now_ms, packet_tag, is_outbound, random_value (low bits first)
    input  logic [rjpd_pkg::IN_W-1:0]     s_axis_tdata,
    // op
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_tag, held_count (low bits first)
    output logic [rjpd_pkg::OUT_W-1:0]    m_axis_tdata,
    // cause
    output logic [rjpd_pkg::CAUSE_W-1:0]  m_axis_tuser,
    output logic                          m_axis_tlast
);
    import rjpd_pkg::*;

    logic [DELAY_W-1:0] r_min, r_max;
    logic r_in_en, r_out_en;
    t_cmd cmd;
    t_sts sts;
    logic idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= DELAY_W'(20);
            r_max <= DELAY_W'(100);
            r_in_en <= 1'b1;
            r_out_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN: r_min <= i_cfg_data;
                REG_MAX: r_max <= i_cfg_data;
                REG_IN:  r_in_en <= i_cfg_data[0];
                REG_OUT: r_out_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = idle;

    rjpd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid), .i_op(s_axis_tuser),
        .o_idle(idle), .o_cmd(cmd), .i_sts(sts)
    );

    rjpd_dp #(.CAPACITY(CAPACITY), .FLUSH_COUNT(FLUSH_COUNT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(s_axis_tdata),
        .i_min(r_min), .i_max(r_max), .i_in_en(r_in_en), .i_out_en(r_out_en),
        .i_cmd(cmd), .o_sts(sts), .i_out_take(m_axis_tready),
        .o_out_valid(m_axis_tvalid), .o_out_data(m_axis_tdata),
        .o_out_user(m_axis_tuser), .o_out_last(m_axis_tlast)
    );

endmodule
